// ----- design/rbxs_pkg.sv -----
// rbxs_pkg: shared types and constants for the relative branch xref scanner
// beat structs, configuration struct, architecture and register index codes
`timescale 1ns / 1ps

package rbxs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] match_position;
    logic [31:0] displacement_value;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] target_offset;
    logic [1:0]  arch_mode;
    logic        little_endian;
    logic [31:0] range_limit;
    logic [31:0] scan_start;
    logic [31:0] scan_end;
  } cfg_t;

  // candidate handed from the window stage to the match logic
  typedef struct packed {
    logic [31:0]     pos_i;
    logic [3:0][7:0] win;
  } cand_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_START    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_END      = 3'd5;

  localparam logic [1:0] MODE_PPC = 2'd0;
  localparam logic [1:0] MODE_ARM = 2'd1;
  localparam logic [1:0] MODE_X86 = 2'd2;

  localparam logic [31:0] SCAN_START_RST = 32'd1;
  localparam logic [31:0] SCAN_END_RST   = 32'd2147483647;

  localparam logic [31:0] ARM_PIPE_OFFSET = 32'd8;
  localparam logic [31:0] X86_INSN_LEN    = 32'd5;

endpackage

// ----- design/rbxs_cfg_regs.sv -----
// rbxs_cfg_regs: configuration register file written through the plain write port
// depends on rbxs_pkg
`timescale 1ns / 1ps

module rbxs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rbxs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output rbxs_pkg::cfg_t                cfg
);
  import rbxs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET_OFFSET: cfg_nxt.target_offset = cfg_wdata;
        REG_ARCH_MODE:     cfg_nxt.arch_mode     = cfg_wdata[1:0];
        REG_LITTLE_ENDIAN: cfg_nxt.little_endian = cfg_wdata[0];
        REG_RANGE_LIMIT:   cfg_nxt.range_limit   = cfg_wdata;
        REG_SCAN_START:    cfg_nxt.scan_start    = cfg_wdata;
        REG_SCAN_END:      cfg_nxt.scan_end      = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_offset <= '0;
      cfg_r.arch_mode     <= MODE_PPC;
      cfg_r.little_endian <= 1'b0;
      cfg_r.range_limit   <= '0;
      cfg_r.scan_start    <= SCAN_START_RST;
      cfg_r.scan_end      <= SCAN_END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/rbxs_front.sv -----
// rbxs_front: byte window, file position counter and candidate register
// depends on rbxs_pkg
`timescale 1ns / 1ps

module rbxs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rbxs_pkg::cfg_t     cfg,
  input  logic               in_accept,
  input  rbxs_pkg::in_beat_t in_beat,
  input  logic               take,
  output logic               cand_valid,
  output rbxs_pkg::cand_t    cand
);
  import rbxs_pkg::*;

  logic [3:0][7:0] win_r, win_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic            cand_valid_r, cand_valid_nxt;
  cand_t           cand_r, cand_nxt;

  logic [31:0] p;
  logic [31:0] lag;
  logic [31:0] minp;
  logic        arch_ok;

  always_comb begin
    p = in_beat.first_byte ? 32'd0 : pos_r;
    unique case (cfg.arch_mode)
      MODE_PPC: begin lag = 32'd3; minp = 32'd3; arch_ok = 1'b1; end
      MODE_ARM: begin lag = 32'd1; minp = 32'd2; arch_ok = 1'b1; end
      MODE_X86: begin lag = 32'd4; minp = 32'd4; arch_ok = 1'b1; end
      default:  begin lag = 32'd0; minp = 32'd0; arch_ok = 1'b0; end
    endcase

    win_nxt        = win_r;
    pos_nxt        = pos_r;
    cand_nxt       = cand_r;
    cand_valid_nxt = cand_valid_r && !take;
    if (in_accept) begin
      win_nxt        = {win_r[2:0], in_beat.data_byte};
      pos_nxt        = p + 32'd1;
      cand_nxt.win   = {win_r[2:0], in_beat.data_byte};
      cand_nxt.pos_i = p - lag;
      cand_valid_nxt = arch_ok && (p >= minp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      pos_r        <= '0;
      cand_valid_r <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      pos_r        <= pos_nxt;
      cand_valid_r <= cand_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_valid = cand_valid_r;
  assign cand       = cand_r;

  pos_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_beat.first_byte |=> pos_r == 32'd1)
    else $error("position not restarted by first byte mark");

endmodule

// ----- design/rbxs_match.sv -----
// rbxs_match: displacement, range and scan window checks and image compare
// depends on rbxs_pkg; purely combinational
`timescale 1ns / 1ps

module rbxs_match (
  input  rbxs_pkg::cfg_t      cfg,
  input  rbxs_pkg::cand_t     cand,
  output logic                hit,
  output rbxs_pkg::out_beat_t result
);
  import rbxs_pkg::*;

  logic [31:0]     v;
  logic [31:0]     mag;
  logic [31:0]     arm_w;
  logic [31:0]     a;
  logic [3:0][7:0] img;
  logic            in_scan;
  logic            in_range;
  logic            bytes_eq;
  logic [31:0]     delta;

  always_comb begin
    delta    = (cfg.arch_mode == MODE_X86) ? 32'd0 : 32'd1;
    v        = cfg.target_offset - cand.pos_i + delta;
    mag      = v[31] ? (32'd0 - v) : v;
    in_range = (cfg.range_limit == 32'd0) || (mag <= cfg.range_limit);
    in_scan  = (cand.pos_i >= cfg.scan_start) && (cand.pos_i < cfg.scan_end);
    arm_w    = v - ARM_PIPE_OFFSET;

    unique case (cfg.arch_mode)
      MODE_ARM: a = {{2{arm_w[31]}}, arm_w[31:2]};
      MODE_X86: a = v - X86_INSN_LEN;
      default:  a = v;
    endcase

    // img[0] is the first byte of the instruction field
    for (int m = 0; m < 4; m++) begin
      img[m] = cfg.little_endian ? a[8*m +: 8] : a[8*(3-m) +: 8];
    end

    unique case (cfg.arch_mode)
      MODE_PPC: bytes_eq = (cand.win[2] == img[1]) && (cand.win[1] == img[2]) &&
                           (cand.win[0] == img[3]);
      MODE_ARM: bytes_eq = (cand.win[2] == img[0]) && (cand.win[1] == img[1]) &&
                           (cand.win[0] == img[2]);
      MODE_X86: bytes_eq = (cand.win[3] == img[0]) && (cand.win[2] == img[1]) &&
                           (cand.win[1] == img[2]) && (cand.win[0] == img[3]);
      default:  bytes_eq = 1'b0;
    endcase

    hit = in_scan && in_range && bytes_eq;
    result.match_position     = (cfg.arch_mode == MODE_ARM) ? (cand.pos_i - 32'd1)
                                                            : cand.pos_i;
    result.displacement_value = v;
  end

endmodule

// ----- design/relative_branch_xref_scanner_unit.sv -----
// a result beat passes through the candidate register and then the result register after its byte beat is accepted
// throughput: one byte beat per cycle while in_stall is low; candidate register and result register
// form the two stages, so one byte is still taken while a result waits
// reset (rst_n low, synchronous): registers to defaults, window and position
// cleared, both stages emptied
// top level of the relative branch xref scanner; depends on rbxs_pkg and submodules
`timescale 1ns / 1ps

module relative_branch_xref_scanner_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbxs_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rbxs_pkg::out_beat_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [rbxs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import rbxs_pkg::*;

  cfg_t      cfg;
  cand_t     cand;
  logic      cand_valid;
  logic      hit;
  out_beat_t result;
  logic      take;
  logic      in_accept;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  rbxs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rbxs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_accept  (in_accept),
    .in_beat    (in_data),
    .take       (take),
    .cand_valid (cand_valid),
    .cand       (cand)
  );

  rbxs_match u_match (
    .cfg    (cfg),
    .cand   (cand),
    .hit    (hit),
    .result (result)
  );

  // result register can load when empty or being drained
  assign take      = !out_valid_r || !out_stall;
  assign in_stall  = cand_valid && !take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      out_valid_nxt = cand_valid && hit;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    cand_valid && take && hit |=> out_valid_r)
    else $error("matching candidate lost before result register");

  no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && cand_valid |-> in_stall)
    else $error("byte beat accepted with both stages full");

  drained_cand: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept && take |=> !cand_valid)
    else $error("candidate kept after it was consumed");

endmodule
